@@ sv/cau_pkg.sv @@
// Shared types, constants and helpers for the complex arithmetic unit.
package cau_pkg;

    localparam int DATA_WIDTH = 16;
    localparam int FRAC_BITS  = 8;
    localparam int PROD_W     = 2 * DATA_WIDTH + 1;
    localparam int DEN_W      = 2 * DATA_WIDTH + 1;
    localparam int QUOT_W     = PROD_W + FRAC_BITS;
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = 2;

    typedef enum logic [1:0] {
        MODE_ADD = 2'd0,
        MODE_SUB = 2'd1,
        MODE_MUL = 2'd2,
        MODE_DIV = 2'd3
    } mode_t;

    typedef struct packed {
        mode_t                         mode;
        logic signed [DATA_WIDTH-1:0]  a_re;
        logic signed [DATA_WIDTH-1:0]  a_im;
        logic signed [DATA_WIDTH-1:0]  b_re;
        logic signed [DATA_WIDTH-1:0]  b_im;
        logic                          div_zero;
    } req_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] res_re;
        logic signed [DATA_WIDTH-1:0] res_im;
        logic                         saturated;
        logic                         div_zero;
    } res_t;

    localparam logic signed [QUOT_W:0] SAT_MAX = (QUOT_W+1)'((1 << (DATA_WIDTH-1)) - 1);
    localparam logic signed [QUOT_W:0] SAT_MIN = -(QUOT_W+1)'(1 << (DATA_WIDTH-1));

    function automatic logic [DATA_WIDTH:0] sat_word(input logic signed [QUOT_W:0] v);
        logic [DATA_WIDTH:0] r;
        if (v > SAT_MAX)
            r = {1'b1, SAT_MAX[DATA_WIDTH-1:0]};
        else if (v < SAT_MIN)
            r = {1'b1, SAT_MIN[DATA_WIDTH-1:0]};
        else
            r = {1'b0, v[DATA_WIDTH-1:0]};
        return r;
    endfunction

endpackage

@@ sv/cau_front.sv @@
// Front end: accepts requests, flags division by zero and queues them.
module cau_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  cau_pkg::req_t       in_req,
    output logic                q_valid,
    input  logic                q_ready,
    output cau_pkg::req_t       q_req
);

    cau_pkg::req_t              mem [cau_pkg::QDEPTH];
    logic [cau_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [cau_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [cau_pkg::QPTR_W:0]   count_reg;
    logic [cau_pkg::QPTR_W:0]   count_next;
    logic                       push;
    logic                       pop;
    cau_pkg::req_t              cls;

    always_comb
    begin
        cls = in_req;
        cls.div_zero = (in_req.mode == cau_pkg::MODE_DIV) &&
                       (in_req.b_re == '0) && (in_req.b_im == '0);
    end

    assign in_ready = (count_reg != (cau_pkg::QPTR_W+1)'(cau_pkg::QDEPTH));
    assign q_valid  = (count_reg != '0);
    assign q_req    = mem[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= cls;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

endmodule

@@ sv/cau_div.sv @@
// Pipelined restoring radix-2 divider: one quotient bit per stage.
module cau_div (
    input  logic                                 clk,
    input  logic                                 en,
    input  logic [cau_pkg::QUOT_W-1:0]           num,
    input  logic [cau_pkg::DEN_W-1:0]            den,
    output logic [cau_pkg::QUOT_W-1:0]           quot
);

    localparam int N = cau_pkg::QUOT_W;
    localparam int RW = cau_pkg::DEN_W + 1;

    logic [N-1:0]  q_reg [N+1];
    logic [RW-1:0] r_reg [N+1];
    logic [cau_pkg::DEN_W-1:0] d_reg [N+1];

    always_comb
    begin
        q_reg[0] = num;
        r_reg[0] = '0;
        d_reg[0] = den;
    end

    for (genvar s = 0; s < N; s++)
    begin : g_stage
        logic [RW-1:0] trial;
        logic          take;
        assign trial = {r_reg[s][RW-2:0], q_reg[s][N-1]};
        assign take  = (trial >= {1'b0, d_reg[s]});
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[s+1] <= take ? trial - {1'b0, d_reg[s]} : trial;
                q_reg[s+1] <= {q_reg[s][N-2:0], take};
                d_reg[s+1] <= d_reg[s];
            end
        end
    end

    assign quot = q_reg[N];

endmodule

@@ sv/cau_back.sv @@
// Back end: pipelined add, subtract, multiply and divide with saturation.
module cau_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    output logic          q_ready,
    input  cau_pkg::req_t q_req,
    output logic          out_valid,
    input  logic          out_ready,
    output cau_pkg::res_t out_res
);

    localparam int W  = cau_pkg::DATA_WIDTH;
    localparam int PW = cau_pkg::PROD_W;
    localparam int QW = cau_pkg::QUOT_W;
    localparam int DL = QW;
    localparam int LAT = 3 + DL;

    logic en;
    logic [LAT-1:0] vld_reg;

    // Stage 1: products, and the sums or differences for add and subtract
    cau_pkg::mode_t          s1_mode_reg;
    logic                    s1_dz_reg;
    logic signed [W:0]       s1_sre_reg, s1_sim_reg;
    logic signed [2*W-1:0]   p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg, p_bb_reg, p_cc_reg;

    // Stage 2: combined
    cau_pkg::mode_t          s2_mode_reg;
    logic                    s2_dz_reg;
    logic signed [QW:0]      s2_re_reg, s2_im_reg;
    logic [cau_pkg::DEN_W-1:0] s2_den_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_mode_reg <= q_req.mode;
            s1_dz_reg   <= q_req.div_zero;
            s1_sre_reg  <= (W+1)'(q_req.a_re) + ((q_req.mode == cau_pkg::MODE_SUB) ?
                           -(W+1)'(q_req.b_re) : (W+1)'(q_req.b_re));
            s1_sim_reg  <= (W+1)'(q_req.a_im) + ((q_req.mode == cau_pkg::MODE_SUB) ?
                           -(W+1)'(q_req.b_im) : (W+1)'(q_req.b_im));
            p_rr_reg <= q_req.a_re * q_req.b_re;
            p_ii_reg <= q_req.a_im * q_req.b_im;
            p_ri_reg <= q_req.a_re * q_req.b_im;
            p_ir_reg <= q_req.a_im * q_req.b_re;
            p_bb_reg <= q_req.b_re * q_req.b_re;
            p_cc_reg <= q_req.b_im * q_req.b_im;
        end
    end

    logic signed [PW-1:0] mr, mi, dr, di;
    assign mr = PW'(p_rr_reg) - PW'(p_ii_reg);
    assign mi = PW'(p_ri_reg) + PW'(p_ir_reg);
    assign dr = PW'(p_rr_reg) + PW'(p_ii_reg);
    assign di = PW'(p_ir_reg) - PW'(p_ri_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_mode_reg <= s1_mode_reg;
            s2_dz_reg   <= s1_dz_reg;
            s2_den_reg  <= cau_pkg::DEN_W'($unsigned(p_bb_reg)) +
                           cau_pkg::DEN_W'($unsigned(p_cc_reg));
            case (s1_mode_reg)
                cau_pkg::MODE_ADD, cau_pkg::MODE_SUB:
                begin
                    s2_re_reg <= (QW+1)'(s1_sre_reg);
                    s2_im_reg <= (QW+1)'(s1_sim_reg);
                end
                cau_pkg::MODE_MUL:
                begin
                    s2_re_reg <= (QW+1)'(mr);
                    s2_im_reg <= (QW+1)'(mi);
                end
                default:
                begin
                    s2_re_reg <= (QW+1)'(dr);
                    s2_im_reg <= (QW+1)'(di);
                end
            endcase
        end
    end

    // Stage 3: magnitudes
    logic [QW-1:0] nre_mag, nim_mag, qre, qim;
    logic [PW-1:0] are_mag, aim_mag;
    assign are_mag = s2_re_reg[PW-1] ? PW'(-s2_re_reg) : PW'(s2_re_reg);
    assign aim_mag = s2_im_reg[PW-1] ? PW'(-s2_im_reg) : PW'(s2_im_reg);
    assign nre_mag = {are_mag, {cau_pkg::FRAC_BITS{1'b0}}};
    assign nim_mag = {aim_mag, {cau_pkg::FRAC_BITS{1'b0}}};

    logic [cau_pkg::DEN_W-1:0] den_safe;
    assign den_safe = (s2_den_reg == '0) ? cau_pkg::DEN_W'(1) : s2_den_reg;

    cau_div u_div_re (.clk(clk), .en(en), .num(nre_mag), .den(den_safe), .quot(qre));
    cau_div u_div_im (.clk(clk), .en(en), .num(nim_mag), .den(den_safe), .quot(qim));

    // Delay line for side info alongside the divider
    cau_pkg::mode_t     dl_mode_reg [DL];
    logic               dl_dz_reg   [DL];
    logic               dl_nre_reg  [DL];
    logic               dl_nim_reg  [DL];
    logic [PW-1:0]      dl_are_reg  [DL];
    logic [PW-1:0]      dl_aim_reg  [DL];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dl_mode_reg[0] <= s2_mode_reg;
            dl_dz_reg[0]   <= s2_dz_reg;
            dl_nre_reg[0]  <= s2_re_reg[PW-1];
            dl_nim_reg[0]  <= s2_im_reg[PW-1];
            dl_are_reg[0]  <= are_mag;
            dl_aim_reg[0]  <= aim_mag;
            for (int i = 1; i < DL; i++)
            begin
                dl_mode_reg[i] <= dl_mode_reg[i-1];
                dl_dz_reg[i]   <= dl_dz_reg[i-1];
                dl_nre_reg[i]  <= dl_nre_reg[i-1];
                dl_nim_reg[i]  <= dl_nim_reg[i-1];
                dl_are_reg[i]  <= dl_are_reg[i-1];
                dl_aim_reg[i]  <= dl_aim_reg[i-1];
            end
        end
    end

    // Final stage: select, scale, saturate
    logic [QW-1:0]      mre, mim;
    logic signed [QW:0] vre, vim;
    logic [W:0]         sre, sim;
    cau_pkg::res_t      res_reg;

    always_comb
    begin
        unique case (dl_mode_reg[DL-1])
            cau_pkg::MODE_ADD, cau_pkg::MODE_SUB:
            begin
                mre = QW'(dl_are_reg[DL-1]);
                mim = QW'(dl_aim_reg[DL-1]);
            end
            cau_pkg::MODE_MUL:
            begin
                mre = QW'(dl_are_reg[DL-1] >> cau_pkg::FRAC_BITS);
                mim = QW'(dl_aim_reg[DL-1] >> cau_pkg::FRAC_BITS);
            end
            default:
            begin
                mre = qre;
                mim = qim;
            end
        endcase
        vre = dl_nre_reg[DL-1] ? -$signed({1'b0, mre}) : $signed({1'b0, mre});
        vim = dl_nim_reg[DL-1] ? -$signed({1'b0, mim}) : $signed({1'b0, mim});
        sre = cau_pkg::sat_word(vre);
        sim = cau_pkg::sat_word(vim);
    end

    assign en      = !vld_reg[LAT-1] || out_ready;
    assign q_ready = en;
    assign out_valid = vld_reg[LAT-1];
    assign out_res   = res_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (dl_dz_reg[DL-1])
            begin
                res_reg <= '{res_re: '0, res_im: '0, saturated: 1'b0, div_zero: 1'b1};
            end
            else
            begin
                res_reg.res_re    <= sre[W-1:0];
                res_reg.res_im    <= sim[W-1:0];
                res_reg.saturated <= sre[W] | sim[W];
                res_reg.div_zero  <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LAT-2:0], q_valid};
    end

endmodule

@@ sv/complex_arithmetic_unit.sv @@
// Top level of the complex arithmetic unit.
// Each request (mode, a, b in Q8.8) yields one result. Throughput is one
// request per cycle while m_tready does not hold the back end. For every
// mode a request passes in order through the queue, the product registers,
// the combine registers, the pipelined divider (one quotient bit per stage)
// and the register that saturates and holds the result. While a result
// waits on m_tready the whole back end holds; the four-entry queue between
// front and back keeps accepting until it is full.
module complex_arithmetic_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,  // mode[1:0], a_re, a_im, b_re, b_im, zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata   // res_re, res_im, saturated, div_zero, zero pad
);

    cau_pkg::req_t in_req, q_req;
    cau_pkg::res_t res;
    logic          q_valid, q_ready;

    always_comb
    begin
        in_req.mode     = cau_pkg::mode_t'(s_tdata[1:0]);
        in_req.a_re     = s_tdata[17:2];
        in_req.a_im     = s_tdata[33:18];
        in_req.b_re     = s_tdata[49:34];
        in_req.b_im     = s_tdata[65:50];
        in_req.div_zero = 1'b0;
    end

    cau_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_tvalid), .in_ready(s_tready), .in_req(in_req),
        .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req)
    );

    cau_back u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_res(res)
    );

    assign m_tdata = {6'b0, res.div_zero, res.saturated, res.res_im, res.res_re};

endmodule

@@ sv/cau_checker.sv @@
// Port-level checker for the complex arithmetic unit, bound to the top level.
module cau_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [71:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped or changed while stalled");

    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[33] |-> m_tdata[31:0] == '0 && !m_tdata[32])
        else $error("divide by zero result not cleared");

    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[39:34] == '0)
        else $error("result padding not zero");

    a_reset_idle: assert property (@(posedge clk)
        !rst_n |-> !m_tvalid)
        else $error("result valid during reset");

endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (.*);
